FILE: sv/mbatr_pkg.sv
// Shared types, character codes and the CRC byte update for the ASCII to RTU converter.
`timescale 1ns / 1ps

package mbatr_pkg;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcSeed = 16'hFFFF;
  localparam logic [7:0]  CountMax = 8'hFF;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);
  localparam logic [FifoCntW-1:0] FifoFull = FifoCntW'(FifoDepth);

  // Result kinds as they appear on the output.
  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_BYTE    = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_LRC_ERR = 3'd3,
    KIND_ABORT   = 3'd4,
    KIND_BAD_END = 3'd5
  } kind_e;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    TOK_COLON,
    TOK_DIGIT,
    TOK_FIRST_END,
    TOK_SECOND_END,
    TOK_OTHER
  } tok_e;

  typedef struct packed {
    tok_e       tok;
    logic [3:0] digit;
  } token_t;

  // Modbus CRC-16 update with one byte, reflected polynomial.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/mbatr_front.sv
// Front end: end-order register and character classification.
`timescale 1ns / 1ps

module mbatr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                end_order_swapped_i,
  input  logic [7:0]          rx_char_i,
  output mbatr_pkg::token_t   token_o
);

  logic       swapped_q;
  logic [7:0] first_end;
  logic [7:0] second_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swapped_q <= 1'b0;
    end else if (cfg_valid_i) begin
      swapped_q <= end_order_swapped_i;
    end
  end

  assign first_end  = swapped_q ? mbatr_pkg::CharLf : mbatr_pkg::CharCr;
  assign second_end = swapped_q ? mbatr_pkg::CharCr : mbatr_pkg::CharLf;

  always_comb begin
    token_o.digit = 4'd0;
    if (rx_char_i == mbatr_pkg::CharColon) begin
      token_o.tok = mbatr_pkg::TOK_COLON;
    end else if (rx_char_i >= mbatr_pkg::CharZero && rx_char_i <= mbatr_pkg::CharNine) begin
      token_o.tok   = mbatr_pkg::TOK_DIGIT;
      token_o.digit = rx_char_i[3:0];
    end else if (rx_char_i >= mbatr_pkg::CharUpA && rx_char_i <= mbatr_pkg::CharUpF) begin
      // 'A' has low nibble 1, so adding nine gives ten.
      token_o.tok   = mbatr_pkg::TOK_DIGIT;
      token_o.digit = rx_char_i[3:0] + 4'd9;
    end else if (rx_char_i == first_end) begin
      token_o.tok = mbatr_pkg::TOK_FIRST_END;
    end else if (rx_char_i == second_end) begin
      token_o.tok = mbatr_pkg::TOK_SECOND_END;
    end else begin
      token_o.tok = mbatr_pkg::TOK_OTHER;
    end
  end

endmodule

FILE: sv/mbatr_fifo.sv
// Small token queue between the front end and the frame engine.
`timescale 1ns / 1ps

module mbatr_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbatr_pkg::token_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mbatr_pkg::token_t rdata_o
);

  mbatr_pkg::token_t                 mem_q [mbatr_pkg::FifoDepth];
  logic [mbatr_pkg::FifoPtrW-1:0]    wptr_q, rptr_q;
  logic [mbatr_pkg::FifoCntW-1:0]    cnt_q;

  assign full_o  = (cnt_q == mbatr_pkg::FifoFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/mbatr_back.sv
// Frame engine: frame state, LRC and CRC sums, counters and the output register.
`timescale 1ns / 1ps

module mbatr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  mbatr_pkg::token_t tok_i,
  output logic              tok_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        kind_o,
  output logic [7:0]        byte_value_o,
  output logic              last_o,
  output logic [7:0]        lrc_fail_count_o,
  output logic [7:0]        end_fail_count_o
);

  logic        in_frame_q, in_frame_d;
  logic        await_q, await_d;
  logic        odd_q, odd_d;
  logic        have_q, have_d;
  logic [3:0]  high_q, high_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  lrc_q, lrc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  lrc_err_q, lrc_err_d;
  logic [7:0]  end_err_q, end_err_d;
  logic        pend_q, pend_d;

  logic             out_valid_q, out_valid_d;
  mbatr_pkg::kind_e kind_q, kind_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic [7:0]       lrc_cnt_q, lrc_cnt_d;
  logic [7:0]       end_cnt_q, end_cnt_d;

  logic       slot_free;
  logic       pop;
  logic [7:0] new_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = tok_valid_i && slot_free && !pend_q;
  assign tok_pop_o = pop;
  assign new_byte  = {high_q, tok_i.digit};

  always_comb begin
    in_frame_d  = in_frame_q;
    await_d     = await_q;
    odd_d       = odd_q;
    have_d      = have_q;
    high_d      = high_q;
    held_d      = held_q;
    lrc_d       = lrc_q;
    crc_d       = crc_q;
    lrc_err_d   = lrc_err_q;
    end_err_d   = end_err_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    byte_d      = byte_q;
    last_d      = last_q;
    lrc_cnt_d   = lrc_cnt_q;
    end_cnt_d   = end_cnt_q;

    if (pend_q && slot_free) begin
      // Second half of the CRC trailer; the CRC does not move while pending.
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      kind_d      = mbatr_pkg::KIND_BYTE;
      byte_d      = crc_q[15:8];
      last_d      = 1'b1;
      lrc_cnt_d   = lrc_err_q;
      end_cnt_d   = end_err_q;
    end else if (pop) begin
      kind_d = mbatr_pkg::KIND_START;
      byte_d = 8'h00;
      last_d = 1'b1;
      if (tok_i.tok == mbatr_pkg::TOK_COLON) begin
        in_frame_d  = 1'b1;
        await_d     = 1'b0;
        odd_d       = 1'b0;
        have_d      = 1'b0;
        high_d      = 4'd0;
        held_d      = 8'h00;
        lrc_d       = 8'h00;
        crc_d       = mbatr_pkg::CrcSeed;
        out_valid_d = 1'b1;
      end else if (!in_frame_q) begin
        // Characters outside a frame are dropped.
      end else if (await_q) begin
        out_valid_d = 1'b1;
        if (tok_i.tok == mbatr_pkg::TOK_SECOND_END) begin
          in_frame_d = 1'b0;
          await_d    = 1'b0;
          if (lrc_q != 8'h00) begin
            kind_d = mbatr_pkg::KIND_LRC_ERR;
            if (lrc_err_q != mbatr_pkg::CountMax) begin
              lrc_err_d = lrc_err_q + 8'd1;
            end
          end else begin
            kind_d = mbatr_pkg::KIND_GOOD;
          end
        end else begin
          kind_d = mbatr_pkg::KIND_BAD_END;
          if (end_err_q != mbatr_pkg::CountMax) begin
            end_err_d = end_err_q + 8'd1;
          end
        end
      end else if (tok_i.tok == mbatr_pkg::TOK_DIGIT) begin
        if (odd_q) begin
          odd_d  = 1'b0;
          lrc_d  = lrc_q + new_byte;
          held_d = new_byte;
          have_d = 1'b1;
          if (have_q) begin
            crc_d       = mbatr_pkg::crc_feed(crc_q, held_q);
            out_valid_d = 1'b1;
            kind_d      = mbatr_pkg::KIND_BYTE;
            byte_d      = held_q;
          end
        end else begin
          high_d = tok_i.digit;
          odd_d  = 1'b1;
        end
      end else if (tok_i.tok == mbatr_pkg::TOK_FIRST_END && !odd_q) begin
        // The held byte is the LRC; the CRC goes out in its place.
        await_d     = 1'b1;
        have_d      = 1'b0;
        pend_d      = 1'b1;
        out_valid_d = 1'b1;
        kind_d      = mbatr_pkg::KIND_BYTE;
        byte_d      = crc_q[7:0];
        last_d      = 1'b0;
      end else begin
        in_frame_d  = 1'b0;
        have_d      = 1'b0;
        out_valid_d = 1'b1;
        kind_d      = mbatr_pkg::KIND_ABORT;
      end
      lrc_cnt_d = lrc_err_d;
      end_cnt_d = end_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      await_q     <= 1'b0;
      odd_q       <= 1'b0;
      have_q      <= 1'b0;
      high_q      <= 4'd0;
      held_q      <= 8'h00;
      lrc_q       <= 8'h00;
      crc_q       <= mbatr_pkg::CrcSeed;
      lrc_err_q   <= 8'h00;
      end_err_q   <= 8'h00;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= mbatr_pkg::KIND_START;
      byte_q      <= 8'h00;
      last_q      <= 1'b0;
      lrc_cnt_q   <= 8'h00;
      end_cnt_q   <= 8'h00;
    end else begin
      in_frame_q  <= in_frame_d;
      await_q     <= await_d;
      odd_q       <= odd_d;
      have_q      <= have_d;
      high_q      <= high_d;
      held_q      <= held_d;
      lrc_q       <= lrc_d;
      crc_q       <= crc_d;
      lrc_err_q   <= lrc_err_d;
      end_err_q   <= end_err_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      byte_q      <= byte_d;
      last_q      <= last_d;
      lrc_cnt_q   <= lrc_cnt_d;
      end_cnt_q   <= end_cnt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign byte_value_o     = byte_q;
  assign last_o           = last_q;
  assign lrc_fail_count_o = lrc_cnt_q;
  assign end_fail_count_o = end_cnt_q;

`ifndef SYNTHESIS
  // A pending CRC high byte always sits behind a low byte still in the output register.
  a_pend_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q) else $error("CRC high byte pending without output");

  // No new character is taken while the CRC trailer is half sent.
  a_pend_blocks_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop) else $error("token popped during CRC trailer");

  // Waiting for the second end character only happens inside a frame.
  a_await_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    await_q |-> in_frame_q) else $error("end wait outside a frame");

  // The error counters never go backward.
  a_lrc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> lrc_err_q >= $past(lrc_err_q)) else $error("LRC counter decreased");

  a_end_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> end_err_q >= $past(end_err_q)) else $error("end counter decreased");
`endif

endmodule

FILE: sv/modbus_ascii_to_rtu_converter.sv
// Top level of the Modbus ASCII to RTU frame converter.
`timescale 1ns / 1ps

// Usage:
// Received ASCII characters enter on the in channel (in_valid_i, in_ready_o,
// rx_char_i), one request per character. Results leave on the out channel
// (out_valid_o, out_ready_i) with kind, RTU byte, a last flag marking the final
// result of a character, and the two saturating error counters.
// The single configuration register, the end order (CR LF or LF CR), is
// written through cfg_valid_i / cfg_ready_o with end_order_swapped_i as data;
// the port is always ready and should only be written while the block is idle.
// The front end classifies each character as it is accepted and writes it into
// a four-entry queue. The frame engine takes one queued character per cycle
// while its output slot is free and no CRC high byte is pending, and registers
// its result; a character passes the queue and then the output register. The
// first end character produces two CRC bytes and so holds the engine until
// the second has been sent, which the queue absorbs.
// When the receiver stalls, the output register holds its result and the
// queue keeps filling; in_ready_o drops only when the queue is full.
// Reset clears the frame state, sums, counters, queue and output register and
// selects CR then LF as the end order.
module modbus_ascii_to_rtu_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       end_order_swapped_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] byte_value_o,
  output logic       last_o,
  output logic [7:0] lrc_fail_count_o,
  output logic [7:0] end_fail_count_o
);

  mbatr_pkg::token_t front_tok;
  mbatr_pkg::token_t head_tok;
  logic              fifo_full;
  logic              fifo_valid;
  logic              fifo_pop;
  logic              push;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_full;
  assign push        = in_valid_i && !fifo_full;

  mbatr_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .end_order_swapped_i (end_order_swapped_i),
    .rx_char_i           (rx_char_i),
    .token_o             (front_tok)
  );

  mbatr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_tok),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .rdata_o (head_tok)
  );

  mbatr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_valid_i      (fifo_valid),
    .tok_i            (head_tok),
    .tok_pop_o        (fifo_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .byte_value_o     (byte_value_o),
    .last_o           (last_o),
    .lrc_fail_count_o (lrc_fail_count_o),
    .end_fail_count_o (end_fail_count_o)
  );

endmodule
